### sv/msf_pkg.sv
// Shared types and constants of the maximal square finder.
// Used by msf_front, msf_back, the top level and the checker; depends on nothing.

package msf_pkg;

   // Map size limits that set the column store and the position counters
   localparam int MSF_MAX_COLS = 1024;
   localparam int MSF_MAX_ROWS = 1024;

   // Entries of the queue between the front and the back part
   localparam int MSF_QUEUE_DEPTH = 4;

   // Character codes after reset
   localparam logic [6:0] MSF_EMPTY_CHAR_RESET    = 7'd46;
   localparam logic [6:0] MSF_OBSTACLE_CHAR_RESET = 7'd111;

   // Configuration register indexes
   typedef enum logic [0:0] {
      MSF_CSR_EMPTY_CHAR    = 1'b0,
      MSF_CSR_OBSTACLE_CHAR = 1'b1
   } msf_csr_type;

   // Map error codes
   typedef enum logic [1:0] {
      MSF_ERR_NONE     = 2'd0,
      MSF_ERR_BAD_CHAR = 2'd1,
      MSF_ERR_ROW_LEN  = 2'd2,
      MSF_ERR_SIZE     = 2'd3
   } msf_err_type;

   // One map cell
   typedef struct packed {
      logic [7:0] cell_char;
      logic       row_end;
      logic       map_end;
   } msf_req_type;

   // One map result
   typedef struct packed {
      logic [10:0] square_size;
      logic [9:0]  top_row;
      logic [9:0]  left_col;
      msf_err_type map_error;
   } msf_rsp_type;

   // Classification of a cell, handed from the front to the back part
   typedef struct packed {
      logic        usable;
      logic        is_empty;
      logic        on_border;
      logic        map_end;
      msf_err_type map_error;
   } msf_flags_type;

endpackage

### sv/msf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.

module msf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/msf_front.sv
// Front part: configuration registers, cell classification, position
// counters and error detection. Uses msf_pkg types.

module msf_front import msf_pkg::*; #(
   parameter int MAX_COLS = MSF_MAX_COLS,
   parameter int MAX_ROWS = MSF_MAX_ROWS,
   localparam int CNT_W   = $clog2(MAX_COLS + 1),
   localparam int RCNT_W  = $clog2(MAX_ROWS + 1),
   localparam int CIDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int RIDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  msf_csr_type       csr_index,
   input  logic [6:0]        csr_wdata,
   // cells
   input  logic              req_valid,
   output logic              req_stall,
   input  msf_req_type       req,
   // queue write side
   input  logic              queue_full,
   output logic              push_valid,
   output msf_flags_type     push_flags,
   output logic [RIDX_W-1:0] push_row,
   output logic [CIDX_W-1:0] push_col
);

   logic [6:0]        empty_ff, empty_in;
   logic [6:0]        obstacle_ff, obstacle_in;
   logic [CNT_W-1:0]  col_ff, col_in;
   logic [RCNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0]  width_ff, width_in;
   msf_err_type       err_ff, err_in;

   logic              accept;
   logic              is_obs;
   logic              is_empty;
   logic              col_at_max;
   logic              over_size;
   logic              too_long;
   logic              too_short;
   logic              line_end;
   logic [CNT_W-1:0]  row_width;
   msf_err_type       err_next;

   assign csr_ready  = 1'b1;
   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign push_valid = accept;

   // Configuration writes
   always_comb begin
      empty_in    = empty_ff;
      obstacle_in = obstacle_ff;
      if (csr_valid) begin
         case (csr_index)
            MSF_CSR_EMPTY_CHAR:    empty_in    = csr_wdata;
            MSF_CSR_OBSTACLE_CHAR: obstacle_in = csr_wdata;
            default: begin
               empty_in    = empty_ff;
               obstacle_in = obstacle_ff;
            end
         endcase
      end
   end

   // Classify the cell and check it against the map geometry
   always_comb begin
      is_obs     = req.cell_char == {1'b0, obstacle_ff};
      is_empty   = !is_obs && (req.cell_char == {1'b0, empty_ff});
      col_at_max = col_ff >= CNT_W'(MAX_COLS);
      over_size  = col_at_max || (row_ff >= RCNT_W'(MAX_ROWS));
      too_long   = (row_ff != '0) && (col_ff >= width_ff);
      line_end   = req.row_end || req.map_end;
      row_width  = col_at_max ? CNT_W'(MAX_COLS) : col_ff + CNT_W'(1);
      too_short  = line_end && (row_ff != '0) && (row_width < width_ff);

      // First error of the map sticks; within a cell: character, size, length
      err_next = err_ff;
      if (err_next == MSF_ERR_NONE && !is_obs && !is_empty) begin
         err_next = MSF_ERR_BAD_CHAR;
      end
      if (over_size) begin
         if (err_next == MSF_ERR_NONE) begin
            err_next = MSF_ERR_SIZE;
         end
      end else if (too_long) begin
         if (err_next == MSF_ERR_NONE) begin
            err_next = MSF_ERR_ROW_LEN;
         end
      end
      if (too_short && err_next == MSF_ERR_NONE) begin
         err_next = MSF_ERR_ROW_LEN;
      end
   end

   // Advance the position counters, clear them at map end
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      width_in = width_ff;
      err_in   = err_ff;
      if (accept) begin
         err_in = err_next;
         if (line_end) begin
            col_in = '0;
            if (row_ff == '0) begin
               width_in = row_width;
            end
            if (row_ff < RCNT_W'(MAX_ROWS)) begin
               row_in = row_ff + RCNT_W'(1);
            end
         end else if (!col_at_max) begin
            col_in = col_ff + CNT_W'(1);
         end
         if (req.map_end) begin
            col_in   = '0;
            row_in   = '0;
            width_in = '0;
            err_in   = MSF_ERR_NONE;
         end
      end
   end

   // Queue entry
   always_comb begin
      push_flags.usable    = !over_size && !too_long;
      push_flags.is_empty  = is_empty;
      push_flags.on_border = (row_ff == '0) || (col_ff == '0);
      push_flags.map_end   = req.map_end;
      push_flags.map_error = err_next;
      push_row             = row_ff[RIDX_W-1:0];
      push_col             = col_ff[CIDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff    <= MSF_EMPTY_CHAR_RESET;
         obstacle_ff <= MSF_OBSTACLE_CHAR_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         width_ff    <= '0;
         err_ff      <= MSF_ERR_NONE;
      end else begin
         empty_ff    <= empty_in;
         obstacle_ff <= obstacle_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         width_ff    <= width_in;
         err_ff      <= err_in;
      end
   end

endmodule

### sv/msf_queue.sv
// Short register queue between the front and the back part.
// Stand-alone; no package needed.

module msf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             full,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = data_ff[rd_ptr_ff];
   assign push      = in_valid && !full;
   assign pop       = out_valid && out_ready;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold entries
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### sv/msf_back.sv
// Back part: column store, square recurrence, best square tracking and
// the result register. Uses msf_pkg types and msf_ram.

module msf_back import msf_pkg::*; #(
   parameter int MAX_COLS = MSF_MAX_COLS,
   parameter int MAX_ROWS = MSF_MAX_ROWS,
   localparam int CIDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int RIDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int MIN_DIM = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS,
   localparam int VAL_W   = $clog2(MIN_DIM + 1)
) (
   input  logic              clock,
   input  logic              reset,
   // queue read side
   input  logic              pop_valid,
   output logic              pop_ready,
   input  msf_flags_type     pop_flags,
   input  logic [RIDX_W-1:0] pop_row,
   input  logic [CIDX_W-1:0] pop_col,
   // results
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msf_rsp_type       rsp
);

   // Cell in the compute stage
   logic              b_valid_ff, b_valid_in;
   msf_flags_type     b_flags_ff;
   logic [RIDX_W-1:0] b_row_ff;
   logic [CIDX_W-1:0] b_col_ff;

   logic [VAL_W-1:0]  left_ff, left_in;
   logic [VAL_W-1:0]  diag_ff, diag_in;
   logic [VAL_W-1:0]  best_size_ff, best_size_in;
   logic [RIDX_W-1:0] best_row_ff, best_row_in;
   logic [CIDX_W-1:0] best_col_ff, best_col_in;
   logic              rsp_valid_ff, rsp_valid_in;
   msf_rsp_type       rsp_ff, rsp_in;

   logic              pop;
   logic              b_adv;
   logic              wr_en;
   logic [VAL_W-1:0]  up;
   logic [VAL_W-1:0]  min_ud;
   logic [VAL_W-1:0]  min_all;
   logic [VAL_W-1:0]  value;
   logic [VAL_W-1:0]  new_size;
   logic [RIDX_W-1:0] new_row;
   logic [CIDX_W-1:0] new_col;
   logic [31:0]       row_calc;
   logic [31:0]       col_calc;
   logic [31:0]       size_ext;
   logic [31:0]       row_ext;
   logic [31:0]       col_ext;

   // Stage control: only a map end cell waits on a stalled result register
   assign b_adv     = b_valid_ff && (!b_flags_ff.map_end || !rsp_valid_ff || !rsp_stall);
   assign pop       = pop_valid && (!b_valid_ff || b_adv);
   assign pop_ready = pop;
   assign wr_en     = b_adv && b_flags_ff.usable;

   // Column store: read on pop, written back when a usable cell completes
   msf_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_COLS)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_col_ff),
      .wr_data (value),
      .rd_en   (pop),
      .rd_addr (pop_col),
      .rd_data (up)
   );

   // Square recurrence and best square update
   always_comb begin
      min_ud  = (up < diag_ff) ? up : diag_ff;
      min_all = (min_ud < left_ff) ? min_ud : left_ff;
      if (!b_flags_ff.is_empty) begin
         value = '0;
      end else if (b_flags_ff.on_border) begin
         value = VAL_W'(1);
      end else begin
         value = min_all + VAL_W'(1);
      end

      row_calc = 32'(b_row_ff) + 32'd1 - 32'(value);
      col_calc = 32'(b_col_ff) + 32'd1 - 32'(value);
      new_size = best_size_ff;
      new_row  = best_row_ff;
      new_col  = best_col_ff;
      if (b_flags_ff.usable && value > best_size_ff) begin
         new_size = value;
         new_row  = row_calc[RIDX_W-1:0];
         new_col  = col_calc[CIDX_W-1:0];
      end
   end

   // Next state of the compute stage
   always_comb begin
      b_valid_in   = b_valid_ff;
      left_in      = left_ff;
      diag_in      = diag_ff;
      best_size_in = best_size_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      if (b_adv) begin
         b_valid_in = 1'b0;
         if (b_flags_ff.usable) begin
            left_in = value;
            diag_in = up;
         end
         best_size_in = new_size;
         best_row_in  = new_row;
         best_col_in  = new_col;
         if (b_flags_ff.map_end) begin
            left_in      = '0;
            diag_in      = '0;
            best_size_in = '0;
            best_row_in  = '0;
            best_col_in  = '0;
         end
      end
      if (pop) begin
         b_valid_in = 1'b1;
      end
   end

   // Result register: load at map end, drop when taken
   always_comb begin
      size_ext     = 32'(new_size);
      row_ext      = 32'(new_row);
      col_ext      = 32'(new_col);
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (b_adv && b_flags_ff.map_end) begin
         rsp_valid_in     = 1'b1;
         rsp_in.map_error = b_flags_ff.map_error;
         if (b_flags_ff.map_error != MSF_ERR_NONE) begin
            rsp_in.square_size = '0;
            rsp_in.top_row     = '0;
            rsp_in.left_col    = '0;
         end else begin
            rsp_in.square_size = size_ext[10:0];
            rsp_in.top_row     = row_ext[9:0];
            rsp_in.left_col    = col_ext[9:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         left_ff      <= '0;
         diag_ff      <= '0;
         best_size_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         left_ff      <= left_in;
         diag_ff      <= diag_in;
         best_size_ff <= best_size_in;
         best_row_ff  <= best_row_in;
         best_col_ff  <= best_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         b_flags_ff <= pop_flags;
         b_row_ff   <= pop_row;
         b_col_ff   <= pop_col;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### sv/maximal_square_finder_core.sv
// Top level of the maximal square finder: front part, queue, back part.
// Depends on msf_pkg, msf_front, msf_queue, msf_back and msf_ram.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   req     | in        | req_valid/req_stall| msf_req_type: one map cell
//   rsp     | out       | rsp_valid/rsp_stall| msf_rsp_type: one result per map
//   csr     | in        | csr_valid/csr_ready| csr_index, csr_wdata (7 bits)
//
// One cell per clock while the queue has room; the column store has one read
// and one write port, which sets that figure.
// A map end cell reaches the result register via the queue and compute stage.
// Reset is synchronous; no clearing pass: a column is always written in
// the first row of a map before a later row reads it.
// A four-entry queue decouples the two parts; a stalled result holds only
// a map end cell in the back part, and req_stall rises once the queue fills.

module maximal_square_finder_core import msf_pkg::*; #(
   parameter int MAX_COLS = MSF_MAX_COLS,
   parameter int MAX_ROWS = MSF_MAX_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  msf_csr_type csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  msf_req_type req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output msf_rsp_type rsp
);

   localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int Q_W    = $bits(msf_flags_type) + RIDX_W + CIDX_W;

   logic              queue_full;
   logic              push_valid;
   msf_flags_type     push_flags;
   logic [RIDX_W-1:0] push_row;
   logic [CIDX_W-1:0] push_col;
   logic              pop_valid;
   logic              pop_ready;
   logic [Q_W-1:0]    pop_data;
   msf_flags_type     pop_flags;
   logic [RIDX_W-1:0] pop_row;
   logic [CIDX_W-1:0] pop_col;

   msf_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_flags (push_flags),
      .push_row   (push_row),
      .push_col   (push_col)
   );

   msf_queue #(
      .WIDTH (Q_W),
      .DEPTH (MSF_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_data   ({push_flags, push_row, push_col}),
      .full      (queue_full),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   // Split the queue entry
   assign {pop_flags, pop_row, pop_col} = pop_data;

   msf_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_flags (pop_flags),
      .pop_row   (pop_row),
      .pop_col   (pop_col),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

### sv/msf_checker.sv
// Port-level checks of the maximal square finder and their binding.
// Depends on msf_pkg and maximal_square_finder_core.

module msf_checker import msf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input msf_rsp_type rsp
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result changed");

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

   // A failed map reports no square
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.map_error != MSF_ERR_NONE |->
         rsp.square_size == '0 && rsp.top_row == '0 && rsp.left_col == '0)
      else $error("square reported with map error");

   // An empty result has its corner at the origin
   a_none_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.square_size == '0 |-> rsp.top_row == '0 && rsp.left_col == '0)
      else $error("corner set without a square");

endmodule

bind maximal_square_finder_core msf_checker u_msf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

### tb/maximal_square_finder_core_tb.sv
// Testbench of maximal_square_finder_core: streams character maps, predicts each
// map's largest empty square and compares every result field by field.
// Depends on msf_pkg and maximal_square_finder_core.

module maximal_square_finder_core_tb;
   import msf_pkg::*;

   localparam int QUIET_LIMIT = 4000;   // cycles with no handshake before giving up
   localparam int LONG_HOLD   = 400;    // receiver hold-off under back pressure
   localparam int SETTLE      = 8;      // pause after the last result of a phase
   localparam int PHASE_CELLS = 60;     // random cells per configuration phase

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   msf_csr_type csr_index = MSF_CSR_EMPTY_CHAR;
   logic [6:0]  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   msf_req_type req = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   msf_rsp_type rsp;

   maximal_square_finder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Handshakes seen at the last rising edge
   logic cell_fire = 1'b0;
   logic rsp_fire  = 1'b0;
   logic csr_fire  = 1'b0;

   // Cells waiting to be offered, and map results still due
   msf_req_type cells_pending [$];
   msf_rsp_type squares_due [$];
   int          cells_queued = 0;
   int          fault_count = 0;

   // Controls set by the sequence, read by the driver, the receiver and the cell generator
   logic burst_mode = 1'b0;
   logic hold_req   = 1'b0;
   logic [6:0] gen_empty    = MSF_EMPTY_CHAR_RESET;
   logic [6:0] gen_obstacle = MSF_OBSTACLE_CHAR_RESET;

   // Predictor state: codes, column store and running search
   logic [6:0]  code_empty;
   logic [6:0]  code_obstacle;
   logic [10:0] up_row [MSF_MAX_COLS];
   logic [10:0] left_len;
   logic [10:0] diag_len;
   logic [10:0] col_at;
   logic [10:0] row_at;
   logic [10:0] first_width;
   logic [10:0] best_len;
   logic [9:0]  best_top;
   logic [9:0]  best_left;
   msf_err_type map_fault;

   function automatic void clear_search();
      left_len    = '0;
      diag_len    = '0;
      col_at      = '0;
      row_at      = '0;
      first_width = '0;
      best_len    = '0;
      best_top    = '0;
      best_left   = '0;
      map_fault   = MSF_ERR_NONE;
   endfunction

   // Keep the first error of a map
   function automatic void flag_fault(msf_err_type code);
      if (map_fault == MSF_ERR_NONE) map_fault = code;
   endfunction

   // Advance the search by one cell; queue the map result on map end
   function automatic void track_cell(msf_req_type c);
      logic        is_obst;
      logic        is_free;
      logic        in_search;
      logic [10:0] up_len;
      logic [10:0] cell_len;
      logic [10:0] low_len;
      logic [10:0] line_width;
      msf_rsp_type res;
      is_obst   = (c.cell_char == {1'b0, code_obstacle});
      is_free   = !is_obst && (c.cell_char == {1'b0, code_empty});
      in_search = 1'b1;
      if (!is_obst && !is_free) flag_fault(MSF_ERR_BAD_CHAR);
      if (col_at >= MSF_MAX_COLS || row_at >= MSF_MAX_ROWS) begin
         flag_fault(MSF_ERR_SIZE);
         in_search = 1'b0;
      end else if (row_at != 0 && col_at >= first_width) begin
         flag_fault(MSF_ERR_ROW_LEN);
         in_search = 1'b0;
      end
      if (in_search) begin
         up_len = up_row[col_at];
         if (!is_free) begin
            cell_len = '0;
         end else if (row_at == 0 || col_at == 0) begin
            cell_len = 11'd1;
         end else begin
            low_len = (up_len < diag_len) ? up_len : diag_len;
            if (left_len < low_len) low_len = left_len;
            cell_len = low_len + 11'd1;
         end
         diag_len       = up_len;
         left_len       = cell_len;
         up_row[col_at] = cell_len;
         // Strictly larger only: the first square in raster order wins
         if (cell_len > best_len) begin
            best_len  = cell_len;
            best_top  = 10'(row_at + 11'd1 - cell_len);
            best_left = 10'(col_at + 11'd1 - cell_len);
         end
      end
      // A map end cell always closes its row
      if (c.row_end || c.map_end) begin
         line_width = (col_at < MSF_MAX_COLS) ? col_at + 11'd1 : 11'(MSF_MAX_COLS);
         if (row_at == 0) first_width = line_width;
         else if (line_width < first_width) flag_fault(MSF_ERR_ROW_LEN);
         col_at = '0;
         if (row_at < MSF_MAX_ROWS) row_at = row_at + 11'd1;
      end else if (col_at < MSF_MAX_COLS) begin
         col_at = col_at + 11'd1;
      end
      if (c.map_end) begin
         res = '0;
         if (map_fault == MSF_ERR_NONE) begin
            res.square_size = best_len;
            res.top_row     = best_top;
            res.left_col    = best_left;
         end
         res.map_error = map_fault;
         squares_due.push_back(res);
         clear_search();
      end
   endfunction

   // Sample handshakes, predict accepted cells, check accepted results
   msf_rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         cell_fire <= 1'b0;
         rsp_fire  <= 1'b0;
         csr_fire  <= 1'b0;
      end else begin
         cell_fire <= req_valid && !req_stall;
         rsp_fire  <= rsp_valid && !rsp_stall;
         csr_fire  <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               MSF_CSR_EMPTY_CHAR:    code_empty    = csr_wdata;
               MSF_CSR_OBSTACLE_CHAR: code_obstacle = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) track_cell(req);
         if (rsp_valid && !rsp_stall) begin
            if (squares_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected result: size %0d row %0d col %0d err %0d",
                           rsp.square_size, rsp.top_row, rsp.left_col, rsp.map_error);
            end else begin
               want = squares_due.pop_front();
               if (rsp.square_size !== want.square_size || rsp.top_row !== want.top_row ||
                   rsp.left_col !== want.left_col || rsp.map_error !== want.map_error) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("mismatch: expected size %0d row %0d col %0d err %0d",
                              want.square_size, want.top_row, want.left_col, want.map_error);
                     $display("          got      size %0d row %0d col %0d err %0d",
                              rsp.square_size, rsp.top_row, rsp.left_col, rsp.map_error);
                  end
               end
            end
         end
      end
   end

   // Offer pending cells with random gaps; hold a stalled item
   int   send_run = 0;
   int   send_wait = 0;
   logic send_calm = 1'b0;
   logic wait_set = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         wait_set  = 1'b0;
      end else if (!req_valid || cell_fire) begin
         if (cells_pending.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            if (!wait_set) begin
               if (send_run == 0) begin
                  send_run  = $urandom_range(4, 60);
                  send_calm = ($urandom_range(0, 2) == 0);
               end
               send_run--;
               send_wait = (send_calm || burst_mode) ? 0 : $urandom_range(0, 9);
               wait_set  = 1'b1;
            end
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else begin
               req       <= cells_pending.pop_front();
               req_valid <= 1'b1;
               wait_set  = 1'b0;
            end
         end
      end
   end

   // Stall results at random; hold off for a long stretch once on request
   int   recv_run = 0;
   int   stall_wait = 0;
   int   hold_left = 0;
   logic recv_calm = 1'b0;
   logic stall_set = 1'b0;
   logic hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_set = 1'b0;
      end else begin
         if (rsp_fire) stall_set = 1'b0;
         if (hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (recv_run == 0) begin
            recv_run  = $urandom_range(4, 60);
            recv_calm = ($urandom_range(0, 2) == 0);
         end
         recv_run--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_valid) begin
            if (!stall_set) begin
               stall_wait = recv_calm ? 0 : $urandom_range(0, 9);
               stall_set  = 1'b1;
            end
            if (stall_wait > 0) begin
               stall_wait--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end else begin
            rsp_stall <= !recv_calm && ($urandom_range(0, 3) == 0);
         end
      end
   end

   // End the run when no handshake happens for too long
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_cell(logic [7:0] ch, logic rend, logic mend);
      msf_req_type c;
      c.cell_char = ch;
      c.row_end   = rend;
      c.map_end   = mend;
      cells_pending.push_back(c);
      cells_queued++;
   endtask

   // Draw a cell code: bad with bad_pct, else empty with free_pct
   function automatic logic [7:0] pick_char(int free_pct, int bad_pct);
      logic [7:0] ch;
      if ($urandom_range(0, 99) < bad_pct) begin
         do ch = 8'($urandom_range(0, 255));
         while (ch == {1'b0, gen_empty} || ch == {1'b0, gen_obstacle});
      end else if ($urandom_range(0, 99) < free_pct) begin
         ch = {1'b0, gen_empty};
      end else begin
         ch = {1'b0, gen_obstacle};
      end
      return ch;
   endfunction

   // Queue one map in raster order; ragged rows vary by one cell
   task automatic queue_map(int rows, int cols, int free_pct, int bad_pct,
                            logic ragged, logic open_end);
      int   width;
      logic last_row;
      logic last_cell;
      for (int r = 0; r < rows; r++) begin
         width = cols;
         if (ragged && r > 0 && $urandom_range(0, 2) == 0)
            width = (cols > 1 && $urandom_range(0, 1) == 1) ? cols - 1 : cols + 1;
         for (int c = 0; c < width; c++) begin
            last_row  = (r == rows - 1);
            last_cell = (c == width - 1);
            queue_cell(pick_char(free_pct, bad_pct), last_cell && !(last_row && open_end),
                       last_row && last_cell);
         end
      end
   endtask

   // Queue a broken map: random row ends and codes, then a map end
   task automatic queue_noise();
      int len;
      len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++)
         queue_cell(pick_char(70, 30), ($urandom_range(0, 3) == 0), (i == len - 1));
   endtask

   task automatic write_csr(msf_csr_type idx, logic [6:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   task automatic set_codes(logic [6:0] e_code, logic [6:0] o_code);
      write_csr(MSF_CSR_EMPTY_CHAR, e_code);
      write_csr(MSF_CSR_OBSTACLE_CHAR, o_code);
      gen_empty    = e_code;
      gen_obstacle = o_code;
      @(posedge clock);
   endtask

   // Wait until every cell is taken and every result is in, then settle
   task automatic drain();
      do @(posedge clock);
      while (cells_pending.size() != 0 || req_valid || squares_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   logic [6:0] phase_empty [6];
   logic [6:0] phase_obst [6];
   int         phase_start;
   int         kind;
   initial begin
      code_empty    = MSF_EMPTY_CHAR_RESET;
      code_obstacle = MSF_OBSTACLE_CHAR_RESET;
      foreach (up_row[i]) up_row[i] = '0;
      clear_search();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed maps under the reset codes
      queue_cell(8'd46, 1'b1, 1'b1);                      // one empty cell
      queue_cell(8'd111, 1'b1, 1'b1);                     // one obstacle
      for (int i = 0; i < 9; i++)                         // 3x3, map end closes the row
         queue_cell(8'd46, (i % 3 == 2) && i != 8, i == 8);
      queue_cell(8'h00, 1'b0, 1'b0);                      // bad codes
      queue_cell(8'hFF, 1'b1, 1'b1);
      queue_cell(8'd46, 1'b0, 1'b0);                      // second row too short
      queue_cell(8'd46, 1'b1, 1'b0);
      queue_cell(8'd46, 1'b1, 1'b1);
      queue_cell(8'd46, 1'b1, 1'b0);                      // second row too long
      queue_cell(8'd46, 1'b0, 1'b0);
      queue_cell(8'd46, 1'b1, 1'b1);
      queue_cell(8'd111, 1'b0, 1'b0);                     // tie: the leftmost wins
      queue_cell(8'd46, 1'b0, 1'b0);
      queue_cell(8'd111, 1'b0, 1'b0);
      queue_cell(8'd46, 1'b1, 1'b1);
      drain();

      phase_empty[0] = 7'd32;   phase_obst[0] = 7'd127;
      phase_empty[1] = 7'd127;  phase_obst[1] = 7'd32;
      phase_empty[2] = 7'd65;   phase_obst[2] = 7'd65;
      phase_empty[3] = 7'($urandom_range(32, 127));
      phase_obst[3]  = 7'($urandom_range(32, 127));
      phase_empty[4] = 7'($urandom_range(32, 127));
      phase_obst[4]  = 7'($urandom_range(32, 127));
      phase_empty[5] = MSF_EMPTY_CHAR_RESET;
      phase_obst[5]  = MSF_OBSTACLE_CHAR_RESET;

      for (int p = 0; p < 6; p++) begin
         set_codes(phase_empty[p], phase_obst[p]);
         if (p == 0) begin
            // Too many columns in the first row
            for (int i = 0; i < 1030; i++) queue_cell({1'b0, gen_empty}, i == 1029, 1'b0);
            queue_cell({1'b0, gen_empty}, 1'b0, 1'b0);
            queue_cell({1'b0, gen_empty}, 1'b1, 1'b1);
         end
         if (p == 2) begin
            // Equal codes: every matching cell is an obstacle
            queue_map(2, 2, 100, 0, 1'b0, 1'b0);
         end
         if (p == 4) begin
            // Fill the block behind a long receiver hold-off
            burst_mode = 1'b1;
            hold_req   = 1'b1;
            for (int i = 0; i < 40; i++) queue_map(1, $urandom_range(1, 2), 80, 0, 1'b0, 1'b0);
            drain();
            hold_req   = 1'b0;
            burst_mode = 1'b0;
         end
         phase_start = cells_queued;
         while (cells_queued - phase_start < PHASE_CELLS) begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
               queue_map($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(55, 100), 0,
                         1'b0, ($urandom_range(0, 3) == 0));
            else if (kind < 85)
               queue_map($urandom_range(2, 6), $urandom_range(1, 6), $urandom_range(50, 100),
                         $urandom_range(0, 8), ($urandom_range(0, 1) == 1),
                         ($urandom_range(0, 3) == 0));
            else
               queue_noise();
         end
         drain();
      end

      if (fault_count == 0 && squares_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
sv/msf_pkg.sv
sv/msf_ram.sv
sv/msf_front.sv
sv/msf_queue.sv
sv/msf_back.sv
sv/maximal_square_finder_core.sv
sv/msf_checker.sv
tb/maximal_square_finder_core_tb.sv
